// File: rtl/core/cnsp_pkg.sv
// Shared types and constants for the CAN node slot protocol block.
// Used by cnsp_step and can_node_slot_protocol; depends on nothing.
package cnsp_pkg;

  // Result kinds
  localparam logic [2:0] KIND_WHOIS    = 3'd0;
  localparam logic [2:0] KIND_VERSION  = 3'd1;
  localparam logic [2:0] KIND_PASS     = 3'd2;
  localparam logic [2:0] KIND_UPLOAD   = 3'd3;
  localparam logic [2:0] KIND_ASSIGNED = 3'd4;

  // Input actions
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_HW_ID  = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  // Frame identifiers and masks
  localparam logic [10:0] ID_WHOIS   = 11'h7A0;
  localparam logic [10:0] ID_ASSIGN  = 11'h7C0;
  localparam logic [10:0] ID_UPLOAD  = 11'h7E0;
  localparam logic [10:0] ID_QUERY   = 11'h7FF;
  localparam logic [10:0] ID_VERSION = 11'h7FF;
  localparam logic [10:0] GROUP_MASK = 11'h7E0;

  localparam logic [63:0] VERSION_DATA = 64'h0000_0000_6463_6261;
  localparam logic [15:0] PERIOD_RESET = 16'd3000;
  localparam logic [3:0]  LEN_FULL     = 4'd8;
  localparam logic [3:0]  LEN_VERSION  = 4'd4;
  localparam logic [3:0]  LEN_QUERY    = 4'd1;

  // One input beat
  typedef struct packed {
    logic        action;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] out_id;
    logic [3:0]  out_len;
    logic [63:0] out_data;
    logic [4:0]  node_slot;
  } result_t;

endpackage

// File: rtl/core/cnsp_step.sv
// Protocol state (slot, tick phase, configuration) and the decision logic
// for one registered item. Depends on cnsp_pkg.
module cnsp_step
  import cnsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  item_t       item,
  input  logic        adv,
  output result_t     res,
  output logic        emit
);

  logic [63:0] hw_id;
  logic [15:0] period;
  logic [4:0]  slot;
  logic [4:0]  slot_next;
  logic [15:0] phase;
  logic [15:0] phase_next;
  logic        announced;
  logic [3:0]  len_eff;
  logic [63:0] data_kept;
  logic [16:0] phase_inc;
  logic        is_query;
  logic        is_assign;
  logic        is_upload;

  // Clamp the length like a CAN DLC and zero bytes beyond it
  always_comb begin
    len_eff = (item.frame_len > LEN_FULL) ? LEN_FULL : item.frame_len;
    for (int i = 0; i < 8; i++) begin
      data_kept[8*i +: 8] = (4'(i) < len_eff) ? item.frame_data[8*i +: 8] : 8'h00;
    end
  end

  // Frame rule tests
  assign is_query  = (item.frame_id == ID_QUERY) && (len_eff == LEN_QUERY) &&
                     (data_kept[7:0] == {3'b000, slot});
  assign is_assign = ((item.frame_id & GROUP_MASK) == ID_ASSIGN) &&
                     (item.frame_id != ID_ASSIGN) && (len_eff == LEN_FULL) &&
                     (data_kept == hw_id);
  assign is_upload = (slot != 5'd0) && (item.frame_id == (ID_UPLOAD | {6'd0, slot}));
  assign phase_inc = {1'b0, phase} + 17'd1;

  // Decide result and next state
  always_comb begin
    slot_next  = slot;
    phase_next = phase;
    emit       = 1'b1;
    res        = '0;
    if (item.action == ACT_TICK) begin
      if (!announced || (phase_inc >= {1'b0, period})) begin
        phase_next = 16'd0;
      end else begin
        phase_next = phase_inc[15:0];
        emit       = 1'b0;
      end
      res.kind     = KIND_WHOIS;
      res.out_id   = ID_WHOIS + {6'd0, slot};
      res.out_len  = LEN_FULL;
      res.out_data = hw_id;
    end else begin
      priority if (is_query) begin
        res.kind     = KIND_VERSION;
        res.out_id   = ID_VERSION;
        res.out_len  = LEN_VERSION;
        res.out_data = VERSION_DATA;
      end else if (is_assign) begin
        slot_next    = item.frame_id[4:0];
        res.kind     = KIND_ASSIGNED;
      end else if (is_upload) begin
        res.kind     = KIND_UPLOAD;
        res.out_id   = item.frame_id;
        res.out_len  = len_eff;
        res.out_data = data_kept;
      end else begin
        res.kind     = KIND_PASS;
        res.out_id   = item.frame_id;
        res.out_len  = len_eff;
        res.out_data = data_kept;
      end
    end
    res.node_slot = slot_next;
  end

  // Commit state when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 5'd0;
      phase     <= 16'd0;
      announced <= 1'b0;
    end else if (adv) begin
      slot  <= slot_next;
      phase <= phase_next;
      if (item.action == ACT_TICK) begin
        announced <= 1'b1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hw_id  <= 64'd0;
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HW_ID:  hw_id  <= cfg_wdata;
        CFG_PERIOD: period <= cfg_wdata[15:0];
        default:    hw_id  <= hw_id;
      endcase
    end
  end

endmodule

// File: rtl/core/can_node_slot_protocol.sv
// Node side of a CAN slot-assignment protocol.
// Channels: s_axis carries received frames (tuser=0) or 1 ms ticks (tuser=1);
// m_axis carries results: WHOIS and version frames to send, frames passed to
// the application, upload frames and slot-assigned notices.
// Configuration: cfg_we/cfg_addr/cfg_wdata write hardware_id (index 0) and
// whois_period (index 1); write only while no beat is in flight.
// Pipeline: an input register, then the decision logic, then an output
// register. One beat per cycle is sustained while m_axis_tready is high; a
// tick that sends nothing leaves no result. The output register lets a new
// beat in while a result waits.
// Stall: when m_axis_tready is low the output register holds and the input
// register fills; s_axis_tready then drops until the result is taken.
// Reset (rst, synchronous) clears both registers, the slot, the tick phase
// and the announce flag; hardware_id resets to 0, whois_period to 3000.
// Depends on cnsp_pkg and cnsp_step.
module can_node_slot_protocol
  import cnsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // frame_id[10:0], frame_len[14:11], frame_data[78:15]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // out_id[10:0], out_len[14:11], out_data[78:15],
                                      // node_slot[83:79]
  output logic [2:0]  m_axis_tuser,   // kind
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic    in_valid;
  item_t   in_item;
  logic    adv;
  result_t res;
  logic    emit;
  result_t out_res;

  // Move the held item on when the output register is free or draining
  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.action     <= s_axis_tuser;
      in_item.frame_id   <= s_axis_tdata[10:0];
      in_item.frame_len  <= s_axis_tdata[14:11];
      in_item.frame_data <= s_axis_tdata[78:15];
    end
  end

  cnsp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item      (in_item),
    .adv       (adv),
    .res       (res),
    .emit      (emit)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {4'd0, out_res.node_slot, out_res.out_data,
                         out_res.out_len, out_res.out_id};

`ifndef ASSERT_OFF
  // Both registers are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !in_valid))
    else $error("pipeline not empty after reset");

  // A held input item is never overwritten by a new beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && in_valid) |-> adv)
    else $error("input register overwritten");

  // WHOIS results carry a full frame in the announce id range
  a_whois_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_WHOIS)) |->
    ((m_axis_tdata[14:11] == LEN_FULL) && (m_axis_tdata[10:5] == ID_WHOIS[10:5])))
    else $error("malformed WHOIS result");
`endif

endmodule
